[sv/ate_pkg.sv]
// Package for the affine transform engine: field widths, item kinds,
// sine table and fixed-point helpers. No dependencies.
package ate_pkg;

   localparam int CoordDims = 3;
   localparam int Mdim = CoordDims + 1;
   localparam int Mcells = Mdim * Mdim;
   localparam int IdxW = $clog2(Mcells);
   localparam int KW = $clog2(Mdim);

   localparam logic [31:0] FxOne = 32'sd65536;

   localparam logic [3:0] KIND_RESET = 4'd0;
   localparam logic [3:0] KIND_SCALE = 4'd1;
   localparam logic [3:0] KIND_TRANS = 4'd2;
   localparam logic [3:0] KIND_ROTX = 4'd3;
   localparam logic [3:0] KIND_ROTY = 4'd4;
   localparam logic [3:0] KIND_ROTZ = 4'd5;
   localparam logic [3:0] KIND_MIRX = 4'd6;
   localparam logic [3:0] KIND_MIRY = 4'd7;
   localparam logic [3:0] KIND_MIRZ = 4'd8;
   localparam logic [3:0] KIND_VERT = 4'd9;

   typedef struct packed {
      logic [3:0] kind;
      logic combine;
      logic signed [31:0] factor_x;
      logic signed [31:0] factor_y;
      logic signed [31:0] factor_z;
      logic [15:0] angle;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic signed [31:0] vert_z;
      logic last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic out_last;
   } rsp_type;

   function automatic logic [16:0] sin_tab(input logic [5:0] i);
      logic [16:0] v;
      begin
         case (i)
            6'd0: v = 17'd0;      6'd1: v = 17'd3216;   6'd2: v = 17'd6424;
            6'd3: v = 17'd9616;   6'd4: v = 17'd12785;  6'd5: v = 17'd15924;
            6'd6: v = 17'd19024;  6'd7: v = 17'd22078;  6'd8: v = 17'd25079;
            6'd9: v = 17'd28020;  6'd10: v = 17'd30893; 6'd11: v = 17'd33692;
            6'd12: v = 17'd36410; 6'd13: v = 17'd39040; 6'd14: v = 17'd41576;
            6'd15: v = 17'd44011; 6'd16: v = 17'd46341; 6'd17: v = 17'd48559;
            6'd18: v = 17'd50660; 6'd19: v = 17'd52639; 6'd20: v = 17'd54491;
            6'd21: v = 17'd56212; 6'd22: v = 17'd57798; 6'd23: v = 17'd59244;
            6'd24: v = 17'd60547; 6'd25: v = 17'd61705; 6'd26: v = 17'd62714;
            6'd27: v = 17'd63572; 6'd28: v = 17'd64277; 6'd29: v = 17'd64827;
            6'd30: v = 17'd65220; 6'd31: v = 17'd65457; default: v = 17'd65536;
         endcase
         return v;
      end
   endfunction

   // magnitude of sin within one quadrant, p in 0..16384
   function automatic logic [16:0] quarter_sin(input logic [14:0] p);
      logic [5:0] i;
      logic [8:0] f;
      logic [16:0] a, b;
      logic [25:0] d;
      begin
         i = {1'b0, p[13:9]};
         f = p[8:0];
         a = sin_tab(i);
         b = sin_tab(i + 6'd1);
         d = (b - a) * f;
         if (p[14]) return 17'd65536;
         return a + 17'(d >> 9);
      end
   endfunction

   function automatic logic signed [31:0] fx_sin(input logic [15:0] a);
      logic [14:0] pos;
      logic [16:0] m;
      begin
         pos = {1'b0, a[13:0]};
         m = a[14] ? quarter_sin(15'd16384 - pos) : quarter_sin(pos);
         return a[15] ? -$signed({15'd0, m}) : $signed({15'd0, m});
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      begin
         if (v > 50'sd2147483647) return 32'h7fffffff;
         if (v < -50'sd2147483648) return 32'h80000000;
         return v[31:0];
      end
   endfunction

endpackage

[sv/ate_if.sv]
// Valid/ready channel carrying one word of a given payload type.
// Depends on ate_pkg for the payload types.
interface ate_req_if;
   logic valid;
   logic ready;
   ate_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ate_rsp_if;
   logic valid;
   logic ready;
   ate_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/ate_mac.sv]
// Shared multiply-accumulate: one 32x32 product per cycle while enabled, registered,
// truncated to Q16.16 and summed exactly. Depends on ate_pkg.
module ate_mac (
   input logic clock,
   input logic clear,
   input logic enable,
   input logic signed [31:0] op_a,
   input logic signed [31:0] op_b,
   input logic acc_en,
   output logic signed [31:0] result
);
   logic signed [63:0] prod_ff, prod_in;
   logic signed [49:0] acc_ff, acc_in;

   always_comb begin
      prod_in = op_a * op_b;
      acc_in = acc_ff;
      if (clear) acc_in = '0;
      else if (acc_en) acc_in = acc_ff + 50'(prod_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      if (enable) prod_ff <= prod_in;
      acc_ff <= acc_in;
   end

   assign result = ate_pkg::sat32(acc_ff);
endmodule

[sv/affine_transform_engine_unit.sv]
// Affine transform engine top level: sequencer around one shared MAC.
// Depends on ate_pkg, ate_if, ate_mac.
// Sequence: compose is decode plus 16 entries of 4 MACs, drain and store;
// vertex (also a transform word with combine clear) is decode plus 3 rows
// of MACs, drain and store, then output; reset/ignored items return to idle
// after decode. One item at a time.
// Reset: synchronous; matrix returns to identity, channel idles.
module affine_transform_engine_unit (
   input logic clock,
   input logic reset,
   ate_req_if.sink req,
   ate_rsp_if.source rsp
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DEC = 3'd1;
   localparam logic [2:0] S_MAC = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_STORE = 3'd4;
   localparam logic [2:0] S_OUT = 3'd5;

   localparam int N = ate_pkg::Mdim;
   localparam int KW = ate_pkg::KW;

   logic [2:0] state_ff, state_in;
   ate_pkg::req_type item_ff;
   logic signed [31:0] mat_ff [ate_pkg::Mcells];
   logic signed [31:0] res_ff [ate_pkg::Mcells];
   logic signed [31:0] elem_ff [ate_pkg::Mcells];
   logic signed [31:0] elem_in [ate_pkg::Mcells];
   logic signed [31:0] sin_ff, cos_ff;
   logic [KW-1:0] i_ff, j_ff, k_ff;
   logic vert_ff; // 1: vertex transform, 0: compose
   logic drain_ff;
   logic signed [31:0] out_ff [ate_pkg::CoordDims];
   logic rsp_valid_ff;
   logic signed [31:0] op_a, op_b, mac_res;
   logic mac_clear, mac_acc;
   logic [ate_pkg::IdxW-1:0] ek, mk, ij;
   logic signed [31:0] vk;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data.out_x = out_ff[0];
   assign rsp.data.out_y = out_ff[1];
   assign rsp.data.out_z = out_ff[2];
   assign rsp.data.out_last = item_ff.last_vertex;

   assign ek = {i_ff, k_ff};
   assign mk = {k_ff, j_ff};
   assign ij = {i_ff, j_ff};

   always_comb begin
      case (k_ff)
         2'd0: vk = item_ff.vert_x;
         2'd1: vk = item_ff.vert_y;
         2'd2: vk = item_ff.vert_z;
         default: vk = ate_pkg::FxOne;
      endcase
      op_a = (vert_ff && item_ff.kind == ate_pkg::KIND_VERT) ? mat_ff[ek] : elem_ff[ek];
      op_b = vert_ff ? vk : mat_ff[mk];
   end

   // elementary matrix for the held word
   always_comb begin
      for (int r = 0; r < ate_pkg::Mcells; r++)
         elem_in[r] = (r % (N + 1) == 0) ? ate_pkg::FxOne : '0;
      case (item_ff.kind)
         ate_pkg::KIND_SCALE: begin
            elem_in[0] = item_ff.factor_x; elem_in[5] = item_ff.factor_y;
            elem_in[10] = item_ff.factor_z;
         end
         ate_pkg::KIND_TRANS: begin
            elem_in[3] = item_ff.factor_x; elem_in[7] = item_ff.factor_y;
            elem_in[11] = item_ff.factor_z;
         end
         ate_pkg::KIND_ROTX: begin
            elem_in[5] = cos_ff; elem_in[6] = -sin_ff;
            elem_in[9] = sin_ff; elem_in[10] = cos_ff;
         end
         ate_pkg::KIND_ROTY: begin
            elem_in[0] = cos_ff; elem_in[2] = sin_ff;
            elem_in[8] = -sin_ff; elem_in[10] = cos_ff;
         end
         ate_pkg::KIND_ROTZ: begin
            elem_in[0] = cos_ff; elem_in[1] = -sin_ff;
            elem_in[4] = sin_ff; elem_in[5] = cos_ff;
         end
         ate_pkg::KIND_MIRX: elem_in[0] = -ate_pkg::FxOne;
         ate_pkg::KIND_MIRY: elem_in[5] = -ate_pkg::FxOne;
         ate_pkg::KIND_MIRZ: elem_in[10] = -ate_pkg::FxOne;
         default: ;
      endcase
   end

   assign mac_clear = (state_ff == S_DEC) || (state_ff == S_STORE);
   assign mac_acc = (state_ff == S_MAC && drain_ff) || state_ff == S_DRAIN;

   ate_mac u_mac (
      .clock(clock), .clear(mac_clear), .enable(state_ff == S_MAC),
      .op_a(op_a), .op_b(op_b), .acc_en(mac_acc), .result(mac_res)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) state_in = S_DEC;
         S_DEC: begin
            if (item_ff.kind == ate_pkg::KIND_RESET || item_ff.kind > ate_pkg::KIND_VERT)
               state_in = S_IDLE;
            else state_in = S_MAC;
         end
         S_MAC: if (k_ff == KW'(N - 1)) state_in = S_DRAIN;
         S_DRAIN: state_in = S_STORE;
         S_STORE: begin
            if (i_ff == KW'(N - 1) && j_ff == KW'(N - 1)) state_in = S_IDLE;
            else if (vert_ff && i_ff == KW'(ate_pkg::CoordDims - 1)) state_in = S_OUT;
            else state_in = S_MAC;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ate_pkg::Mcells; r++)
            mat_ff[r] <= (r % (N + 1) == 0) ? ate_pkg::FxOne : '0;
      end else begin
         state_ff <= state_in;
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               item_ff <= req.data;
               sin_ff <= ate_pkg::fx_sin(req.data.angle);
               cos_ff <= ate_pkg::fx_sin(req.data.angle + 16'd16384);
            end
            S_DEC: begin
               i_ff <= '0; j_ff <= '0; k_ff <= '0; drain_ff <= 1'b0;
               vert_ff <= (item_ff.kind == ate_pkg::KIND_VERT) || !item_ff.combine;
               if (item_ff.kind == ate_pkg::KIND_RESET)
                  for (int r = 0; r < ate_pkg::Mcells; r++)
                     mat_ff[r] <= (r % (N + 1) == 0) ? ate_pkg::FxOne : '0;
               for (int r = 0; r < ate_pkg::Mcells; r++)
                  elem_ff[r] <= elem_in[r];
            end
            S_MAC: begin
               drain_ff <= 1'b1;
               k_ff <= k_ff + KW'(1);
            end
            S_DRAIN: drain_ff <= 1'b0;
            S_STORE: begin
               k_ff <= '0;
               if (vert_ff) out_ff[i_ff] <= mac_res;
               else res_ff[ij] <= mac_res;
               // vertex walks rows only; compose walks all entries
               if (vert_ff) i_ff <= i_ff + KW'(1);
               else begin
                  j_ff <= j_ff + KW'(1);
                  if (j_ff == KW'(N - 1)) i_ff <= i_ff + KW'(1);
               end
               if (!vert_ff && i_ff == KW'(N - 1) && j_ff == KW'(N - 1)) begin
                  for (int r = 0; r < ate_pkg::Mcells - 1; r++) mat_ff[r] <= res_ff[r];
                  mat_ff[ate_pkg::Mcells - 1] <= mac_res;
               end
            end
            S_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("accepted while busy");
   a_out_from_vertex: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> vert_ff) else $error("result from compose");
   a_valid_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT) else $error("stray result");
endmodule

[verif/affine_transform_engine_unit_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for affine_transform_engine_unit: random valid/ready
// traffic on both channels against an in-bench Q16.16 transform predictor.
// Depends on ate_pkg and the ate_req_if / ate_rsp_if channel interfaces.
module affine_transform_engine_unit_test;

   typedef logic signed [31:0] mat_type [ate_pkg::Mcells];

   localparam logic [3:0] KIND_SPARE_LO = 4'd10;
   localparam logic [3:0] KIND_SPARE_HI = 4'd15;
   localparam int RandomWords = 1900;
   localparam int MaxIdle = 18;

   // round(65536*sin(k*pi/64)), k = 0..32
   localparam int SineQuarter [33] = '{
      0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
      25079, 28020, 30893, 33692, 36410, 39040, 41576, 44011,
      46341, 48559, 50660, 52639, 54491, 56212, 57798, 59244,
      60547, 61705, 62714, 63572, 64277, 64827, 65220, 65457,
      65536};

   logic clock;
   logic reset;
   bit failed;

   ate_req_if req ();
   ate_rsp_if rsp ();

   affine_transform_engine_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   ate_pkg::req_type pending_words [$];
   ate_pkg::rsp_type expected_vertices [$];
   mat_type composite;

   function automatic mat_type identity_mat();
      mat_type m;
      for (int i = 0; i < ate_pkg::Mcells; i++) m[i] = 0;
      for (int r = 0; r < ate_pkg::Mdim; r++) m[r * ate_pkg::Mdim + r] = 32'sd65536;
      return m;
   endfunction

   function automatic logic signed [31:0] saturate(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Q16.16 product, floor of the low 16 bits
   function automatic longint fx_mul(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
   endfunction

   function automatic int sine_of(input logic [15:0] a);
      int p, idx, f, m;
      p = a[14] ? 16384 - int'(a[13:0]) : int'(a[13:0]);
      idx = p >> 9;
      f = p & 511;
      if (idx >= 32) m = 65536;
      else m = SineQuarter[idx] + (((SineQuarter[idx + 1] - SineQuarter[idx]) * f) >> 9);
      return a[15] ? -m : m;
   endfunction

   function automatic mat_type elementary(input ate_pkg::req_type w);
      mat_type e;
      logic signed [31:0] s, c;
      e = identity_mat();
      s = sine_of(w.angle);
      c = sine_of(w.angle + 16'd16384);
      case (w.kind)
         ate_pkg::KIND_SCALE: begin
            e[0] = w.factor_x; e[5] = w.factor_y; e[10] = w.factor_z;
         end
         ate_pkg::KIND_TRANS: begin
            e[3] = w.factor_x; e[7] = w.factor_y; e[11] = w.factor_z;
         end
         ate_pkg::KIND_ROTX: begin
            e[5] = c; e[6] = -s; e[9] = s; e[10] = c;
         end
         ate_pkg::KIND_ROTY: begin
            e[0] = c; e[2] = s; e[8] = -s; e[10] = c;
         end
         ate_pkg::KIND_ROTZ: begin
            e[0] = c; e[1] = -s; e[4] = s; e[5] = c;
         end
         ate_pkg::KIND_MIRX: e[0] = -32'sd65536;
         ate_pkg::KIND_MIRY: e[5] = -32'sd65536;
         default: e[10] = -32'sd65536;
      endcase
      return e;
   endfunction

   function automatic ate_pkg::rsp_type transformed(input mat_type t,
                                                    input ate_pkg::req_type w);
      ate_pkg::rsp_type r;
      logic signed [31:0] v [ate_pkg::Mdim];
      logic signed [31:0] o [ate_pkg::CoordDims];
      longint acc;
      v[0] = w.vert_x; v[1] = w.vert_y; v[2] = w.vert_z; v[3] = 32'sd65536;
      for (int i = 0; i < ate_pkg::CoordDims; i++) begin
         acc = 0;
         for (int k = 0; k < ate_pkg::Mdim; k++)
            acc += fx_mul(t[i * ate_pkg::Mdim + k], v[k]);
         o[i] = saturate(acc);
      end
      r.out_x = o[0]; r.out_y = o[1]; r.out_z = o[2];
      r.out_last = w.last_vertex;
      return r;
   endfunction

   // updates the composite and queues the vertex the word produces, if any
   task automatic apply_word(input ate_pkg::req_type w);
      mat_type e, prod;
      longint acc;
      if (w.kind == ate_pkg::KIND_RESET) begin
         composite = identity_mat();
      end else if (w.kind == ate_pkg::KIND_VERT) begin
         expected_vertices.push_back(transformed(composite, w));
      end else if (w.kind <= ate_pkg::KIND_MIRZ) begin
         e = elementary(w);
         if (w.combine) begin
            for (int i = 0; i < ate_pkg::Mdim; i++)
               for (int j = 0; j < ate_pkg::Mdim; j++) begin
                  acc = 0;
                  for (int k = 0; k < ate_pkg::Mdim; k++)
                     acc += fx_mul(e[i * ate_pkg::Mdim + k],
                                   composite[k * ate_pkg::Mdim + j]);
                  prod[i * ate_pkg::Mdim + j] = saturate(acc);
               end
            composite = prod;
         end else begin
            expected_vertices.push_back(transformed(e, w));
         end
      end
   endtask

   function automatic int draw_idle(input bit busy_phase);
      return busy_phase ? $urandom_range(0, MaxIdle) : 0;
   endfunction

   // driver
   int send_gap;
   bit send_busy;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         send_gap = 0;
         composite = identity_mat();
      end else begin
         if (req.valid && req.ready) apply_word(req.data);
         if (!req.valid || req.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req.data <= pending_words.pop_front();
               req.valid <= 1'b1;
               if ($urandom_range(0, 99) == 0) send_busy = !send_busy;
               send_gap = draw_idle(send_busy);
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         failed = 1'b1;
      end
   endtask

   // monitor
   int stall_left;
   bit sink_busy;
   always @(posedge clock) begin
      ate_pkg::rsp_type exp_w;
      bit next_ready;
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left = 0;
      end else begin
         next_ready = rsp.ready;
         if (rsp.valid && rsp.ready) begin
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp.data);
               failed = 1'b1;
            end else begin
               exp_w = expected_vertices.pop_front();
               check_field("out_x", exp_w.out_x, rsp.data.out_x);
               check_field("out_y", exp_w.out_y, rsp.data.out_y);
               check_field("out_z", exp_w.out_z, rsp.data.out_z);
               check_field("out_last", 32'(exp_w.out_last), 32'(rsp.data.out_last));
            end
            if ($urandom_range(0, 99) == 0) sink_busy = !sink_busy;
            stall_left = draw_idle(sink_busy);
            next_ready = (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp.ready <= next_ready;
      end
   end

   function automatic logic [31:0] draw_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
         default: return 32'($urandom_range(0, 32'h0060_0000)) - 32'h0030_0000;
      endcase
   endfunction

   // scale factors near unity keep long compose chains out of saturation
   function automatic logic [31:0] draw_factor(input logic [3:0] kind);
      if (kind == ate_pkg::KIND_SCALE && $urandom_range(0, 3) != 0)
         return 32'($urandom_range(0, 32'h0002_0000)) - 32'h0001_0000
                + ($urandom_range(0, 1) ? 32'h0001_0000 : 32'h0);
      return draw_value();
   endfunction

   function automatic ate_pkg::req_type make_word(input logic [3:0] kind,
                                                  input logic comb,
                                                  input logic [15:0] ang);
      ate_pkg::req_type w;
      w.kind = kind;
      w.combine = comb;
      w.factor_x = draw_factor(kind);
      w.factor_y = draw_factor(kind);
      w.factor_z = draw_factor(kind);
      w.angle = ang;
      w.vert_x = draw_value();
      w.vert_y = draw_value();
      w.vert_z = draw_value();
      w.last_vertex = 1'($urandom_range(0, 1));
      return w;
   endfunction

   function automatic ate_pkg::req_type random_word();
      int pick;
      logic [3:0] kind;
      pick = $urandom_range(0, 99);
      if (pick < 5) kind = ate_pkg::KIND_RESET;
      else if (pick < 8) kind = 4'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      else if (pick < 45) kind = ate_pkg::KIND_VERT;
      else kind = 4'($urandom_range(ate_pkg::KIND_SCALE, ate_pkg::KIND_MIRZ));
      return make_word(kind, $urandom_range(0, 2) != 0, 16'($urandom()));
   endfunction

   initial begin
      ate_pkg::req_type w;
      logic [15:0] angles [6];
      angles = '{16'd0, 16'd8192, 16'd16384, 16'd32768, 16'd49152, 16'hffff};
      failed = 1'b0;
      send_busy = 1'b1;
      sink_busy = 1'b1;
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // corners: identity vertex at extremes, saturating scale, every kind
      w = make_word(ate_pkg::KIND_VERT, 1'b1, 16'd0);
      w.vert_x = 32'sh7fffffff; w.vert_y = 32'sh80000000; w.vert_z = 32'sh7fffffff;
      w.last_vertex = 1'b1;
      pending_words.push_back(w);
      w = make_word(ate_pkg::KIND_SCALE, 1'b0, 16'd0);
      w.factor_x = 32'sh7fffffff; w.factor_y = 32'sh80000000; w.factor_z = 32'sh7fffffff;
      w.vert_x = 32'sh7fffffff; w.vert_y = 32'sh7fffffff; w.vert_z = 32'sh80000000;
      pending_words.push_back(w);
      w = make_word(ate_pkg::KIND_TRANS, 1'b0, 16'd0);
      w.factor_x = 32'sh7fffffff; w.vert_x = 32'sh7fffffff;
      w.last_vertex = 1'b0;
      pending_words.push_back(w);
      for (int a = 0; a < 6; a++)
         pending_words.push_back(make_word(4'(ate_pkg::KIND_ROTX + a % 3), 1'b0, angles[a]));
      pending_words.push_back(make_word(ate_pkg::KIND_MIRX, 1'b0, 16'd0));
      pending_words.push_back(make_word(ate_pkg::KIND_MIRY, 1'b0, 16'd0));
      pending_words.push_back(make_word(ate_pkg::KIND_MIRZ, 1'b0, 16'd0));
      for (logic [3:0] k = ate_pkg::KIND_SCALE; k <= ate_pkg::KIND_MIRZ; k++)
         pending_words.push_back(make_word(k, 1'b1, angles[k % 6]));
      pending_words.push_back(make_word(ate_pkg::KIND_VERT, 1'b1, 16'd0));
      pending_words.push_back(make_word(KIND_SPARE_LO, 1'b0, 16'd0));
      pending_words.push_back(make_word(KIND_SPARE_HI, 1'b1, 16'd0));
      pending_words.push_back(make_word(ate_pkg::KIND_RESET, 1'b1, 16'd0));
      pending_words.push_back(make_word(ate_pkg::KIND_VERT, 1'b0, 16'd0));

      for (int n = 0; n < RandomWords; n++) pending_words.push_back(random_word());

      wait (pending_words.size() == 0);
      @(posedge clock);
      while (req.valid || expected_vertices.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (!failed) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
